/* sv/rrvs_pkg.sv */
// Shared types, constants and helper functions for the rotated rectangle vertex setup.
// Used by rrvs_front, rrvs_fifo, rrvs_back and rotated_rect_vertex_setup_top.
package rrvs_pkg;

    localparam int CFG_W  = 13;
    localparam int TRIG_W = 34;
    localparam int QUO_W  = 16;

    localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1280;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd720;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic [2:0] VTX_LAST = 3'd5;

    localparam logic signed [TRIG_W-1:0] INV_GAIN = 34'sd652032874;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
        logic signed [15:0] pivot_x;
        logic signed [15:0] pivot_y;
        logic [31:0]        color;
    } t_rect;

    typedef struct packed {
        t_rect                     rect;
        logic signed [TRIG_W-1:0]  cos_v;
        logic signed [TRIG_W-1:0]  sin_v;
    } t_job;

    typedef struct packed {
        logic [31:0] color;
        logic [1:0]  corner;
        logic        last;
    } t_meta;

    // One lane of the restoring divider: remainder, dividend bits still to
    // shift in, and the quotient built so far.
    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [CFG_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    function automatic logic signed [TRIG_W-1:0] atan_turn(input int idx);
        case (idx)
            0:  return 34'sd536870912;
            1:  return 34'sd316933406;
            2:  return 34'sd167458907;
            3:  return 34'sd85004756;
            4:  return 34'sd42667331;
            5:  return 34'sd21354465;
            6:  return 34'sd10680862;
            7:  return 34'sd5340245;
            8:  return 34'sd2670163;
            9:  return 34'sd1335087;
            10: return 34'sd667544;
            11: return 34'sd333772;
            12: return 34'sd166886;
            13: return 34'sd83443;
            14: return 34'sd41722;
            15: return 34'sd20861;
            16: return 34'sd10430;
            17: return 34'sd5215;
            18: return 34'sd2608;
            19: return 34'sd1304;
            20: return 34'sd652;
            21: return 34'sd326;
            22: return 34'sd163;
            23: return 34'sd81;
            default: return '0;
        endcase
    endfunction

    function automatic logic [1:0] vtx_corner(input logic [2:0] k);
        case (k)
            3'd0:    return CORNER_TL;
            3'd1:    return CORNER_TR;
            3'd2:    return CORNER_BL;
            3'd3:    return CORNER_TR;
            3'd4:    return CORNER_BR;
            default: return CORNER_BL;
        endcase
    endfunction

    function automatic t_div_lane div_step(input t_div_lane a, input logic [CFG_W-1:0] d);
        t_div_lane     r;
        logic [CFG_W:0] t;
        r = a;
        t = {a.rem, a.low[QUO_W-1]};
        r.low = {a.low[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        r.rem = t[CFG_W-1:0];
        return r;
    endfunction

endpackage

/* sv/rotated_rect_vertex_setup_top.sv */
// Rotated rectangle vertex setup: six triangle-list vertices per rectangle.
// From acceptance to the first vertex, a rectangle passes the CORDIC pipeline, the queue and the back pipeline.
// Throughput: one vertex per cycle when not stalled, set by the back pipeline.
// The front end keeps taking rectangles while the queue has room.
// Synchronous active-low reset clears all valid state and sets the viewport to 1280 x 720.
module rotated_rect_vertex_setup_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [0:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [15:0]    i_size_w,
    input  logic signed [15:0]    i_size_h,
    input  logic signed [15:0]    i_pivot_x,
    input  logic signed [15:0]    i_pivot_y,
    input  logic [15:0]           i_angle,
    input  logic [31:0]           i_color_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_ndc_x,
    output logic signed [15:0]    o_ndc_y,
    output logic [31:0]           o_color_out,
    output logic [1:0]            o_corner,
    output logic                  o_last
);
    import rrvs_pkg::*;

    logic [CFG_W-1:0] r_w, r_h;
    logic [CFG_W-1:0] w_eff, h_eff;
    t_rect            rect;
    t_job             push_job, head_job;
    logic             push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RESET_WIDTH;
            r_h <= RESET_HEIGHT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_w <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero viewport size behaves as one pixel.
    assign w_eff = (r_w == '0) ? CFG_W'(1) : r_w;
    assign h_eff = (r_h == '0) ? CFG_W'(1) : r_h;

    always_comb begin
        rect.pos_x   = i_pos_x;
        rect.pos_y   = i_pos_y;
        rect.size_w  = i_size_w;
        rect.size_h  = i_size_h;
        rect.pivot_x = i_pivot_x;
        rect.pivot_y = i_pivot_y;
        rect.color   = i_color_in;
    end

    rrvs_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_rect  (rect),
        .i_angle (i_angle),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    rrvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    rrvs_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ndc_x     (o_ndc_x),
        .o_ndc_y     (o_ndc_y),
        .o_color_out (o_color_out),
        .o_corner    (o_corner),
        .o_last      (o_last)
    );

endmodule

/* sv/rrvs_front.sv */
// Front end: accepts rectangles and computes cosine and sine of the angle
// in a pipelined CORDIC. Depends on rrvs_pkg.
module rrvs_front #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rrvs_pkg::t_rect i_rect,
    input  logic [15:0]    i_angle,
    output logic           o_stall,
    output logic           o_push,
    output rrvs_pkg::t_job o_job,
    input  logic           i_full
);
    import rrvs_pkg::*;

    logic                     en;
    logic                     r_v    [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] r_y    [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] r_z    [0:CORDIC_STAGES];
    logic [1:0]               r_q    [0:CORDIC_STAGES];
    t_rect                    r_rect [0:CORDIC_STAGES];
    logic                     r_out_v;
    t_job                     r_out;
    t_job                     n_out;
    logic [15:0]              a_rot;
    logic signed [14:0]       resid;
    logic signed [TRIG_W-1:0] z0;

    // The whole pipeline holds only when its finished entry cannot enter the queue.
    assign en      = !(r_out_v && i_full);
    assign o_stall = !en;
    assign o_push  = r_out_v && !i_full;
    assign o_job   = r_out;

    always_comb begin
        a_rot = i_angle + 16'h2000;
        resid = $signed({1'b0, a_rot[13:0]}) - 15'sd8192;
        z0    = {{(TRIG_W-31){resid[14]}}, resid, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= INV_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= z0;
            r_q[0]    <= a_rot[15:14];
            r_rect[0] <= i_rect;
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        localparam logic signed [TRIG_W-1:0] ATAN = atan_turn(gi);
        logic signed [TRIG_W-1:0] xs;
        logic signed [TRIG_W-1:0] ys;

        assign xs = r_x[gi] >>> gi;
        assign ys = r_y[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi+1] <= 1'b0;
            end else if (en) begin
                r_v[gi+1] <= r_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_z[gi][TRIG_W-1]) begin
                    r_x[gi+1] <= r_x[gi] - ys;
                    r_y[gi+1] <= r_y[gi] + xs;
                    r_z[gi+1] <= r_z[gi] - ATAN;
                end else begin
                    r_x[gi+1] <= r_x[gi] + ys;
                    r_y[gi+1] <= r_y[gi] - xs;
                    r_z[gi+1] <= r_z[gi] + ATAN;
                end
                r_q[gi+1]    <= r_q[gi];
                r_rect[gi+1] <= r_rect[gi];
            end
        end
    end

    // Quarter turns are applied exactly after the CORDIC.
    always_comb begin
        n_out.rect = r_rect[CORDIC_STAGES];
        case (r_q[CORDIC_STAGES])
            2'd0: begin
                n_out.cos_v = r_x[CORDIC_STAGES];
                n_out.sin_v = r_y[CORDIC_STAGES];
            end
            2'd1: begin
                n_out.cos_v = -r_y[CORDIC_STAGES];
                n_out.sin_v = r_x[CORDIC_STAGES];
            end
            2'd2: begin
                n_out.cos_v = -r_x[CORDIC_STAGES];
                n_out.sin_v = -r_y[CORDIC_STAGES];
            end
            default: begin
                n_out.cos_v = r_y[CORDIC_STAGES];
                n_out.sin_v = -r_x[CORDIC_STAGES];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

/* sv/rrvs_fifo.sv */
// Short queue of trigonometry results between the front and back ends.
// Depends on rrvs_pkg.
module rrvs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rrvs_pkg::t_job i_data,
    input  logic           i_pop,
    output rrvs_pkg::t_job o_head,
    output logic           o_full,
    output logic           o_empty
);
    import rrvs_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_job          r_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* sv/rrvs_back.sv */
// Back end: issues six vertices per rectangle, rotates and offsets each
// corner, and maps it to NDC through two pipelined dividers. Depends on rrvs_pkg.
module rrvs_back #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rrvs_pkg::t_job         i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic [rrvs_pkg::CFG_W-1:0] i_w,
    input  logic [rrvs_pkg::CFG_W-1:0] i_h,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [15:0]     o_ndc_x,
    output logic signed [15:0]     o_ndc_y,
    output logic [31:0]            o_color_out,
    output logic [1:0]             o_corner,
    output logic                   o_last
);
    import rrvs_pkg::*;

    localparam int SHIFT = COORD_FRAC_BITS + 16;
    localparam int DW    = 17;
    localparam int PW    = DW + TRIG_W;
    localparam int XW    = 52;
    localparam int MW    = 53;

    logic en;
    logic issue;
    logic [2:0] r_k;
    logic [1:0] corner;

    logic signed [MW-1:0] r_half_x, r_half_y, r_bias_x, r_bias_y;

    logic                     r_a_v;
    t_meta                    r_a_m;
    logic signed [DW-1:0]     r_a_dx, r_a_dy;
    logic signed [TRIG_W-1:0] r_a_c, r_a_s;
    logic signed [15:0]       r_a_px, r_a_py;

    logic                 r_b_v;
    t_meta                r_b_m;
    logic signed [PW-1:0] r_b_dxc, r_b_dys, r_b_dxs, r_b_dyc;
    logic signed [15:0]   r_b_px, r_b_py;

    logic                 r_c_v;
    t_meta                r_c_m;
    logic signed [XW-1:0] r_c_x, r_c_y;
    logic signed [XW-1:0] pxs, pys;

    logic                 r_d_v;
    t_meta                r_d_m;
    logic signed [MW-1:0] r_d_x, r_d_y;

    logic                 r_e_v;
    t_meta                r_e_m;
    logic signed [MW-1:0] r_e_x, r_e_y;

    logic      r_dv [0:QUO_W];
    t_meta     r_dm [0:QUO_W];
    t_div_lane r_dx [0:QUO_W];
    t_div_lane r_dy [0:QUO_W];
    t_div_lane init_x, init_y;

    logic               r_o_v;
    t_meta              r_o_m;
    logic signed [15:0] r_o_x, r_o_y;
    logic signed [15:0] n_o_x, n_o_y;

    assign en     = !(r_o_v && i_stall);
    assign issue  = en && !i_empty;
    assign o_pop  = issue && (r_k == VTX_LAST);
    assign corner = vtx_corner(r_k);

    // Rounding offsets and range biases follow from the viewport size.
    always_ff @(posedge i_clk) begin
        r_half_x <= $signed({{(MW-CFG_W){1'b0}}, i_w}) <<< (SHIFT - 1);
        r_half_y <= $signed({{(MW-CFG_W){1'b0}}, i_h}) <<< (SHIFT - 1);
        r_bias_x <= ($signed({{(MW-CFG_W){1'b0}}, i_w}) <<< 13)
                  + ($signed({{(MW-CFG_W){1'b0}}, i_w}) <<< 14);
        r_bias_y <= ($signed({{(MW-CFG_W){1'b0}}, i_h}) <<< 13)
                  + ($signed({{(MW-CFG_W){1'b0}}, i_h}) <<< 14)
                  - $signed({{(MW-CFG_W){1'b0}}, i_h});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (issue) begin
            r_k <= (r_k == VTX_LAST) ? 3'd0 : r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_a_v <= !i_empty;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_o_v <= r_dv[QUO_W];
        end
    end

    assign pxs = {{(XW-46){r_b_px[15]}}, r_b_px, 30'b0};
    assign pys = {{(XW-46){r_b_py[15]}}, r_b_py, 30'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m.color  <= i_head.rect.color;
            r_a_m.corner <= corner;
            r_a_m.last   <= (r_k == VTX_LAST);
            r_a_dx <= (corner[0] ? DW'(i_head.rect.size_w) : '0) - DW'(i_head.rect.pivot_x);
            r_a_dy <= (corner[1] ? DW'(i_head.rect.size_h) : '0) - DW'(i_head.rect.pivot_y);
            r_a_c  <= i_head.cos_v;
            r_a_s  <= i_head.sin_v;
            r_a_px <= i_head.rect.pos_x;
            r_a_py <= i_head.rect.pos_y;

            r_b_m   <= r_a_m;
            r_b_dxc <= r_a_dx * r_a_c;
            r_b_dys <= r_a_dy * r_a_s;
            r_b_dxs <= r_a_dx * r_a_s;
            r_b_dyc <= r_a_dy * r_a_c;
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;

            r_c_m <= r_b_m;
            r_c_x <= pxs + XW'(r_b_dxc) - XW'(r_b_dys);
            r_c_y <= pys + XW'(r_b_dxs) + XW'(r_b_dyc);

            // floor((X + D/2) / D) = floor(floor((X + D/2) / 2^SHIFT) / W)
            r_d_m <= r_c_m;
            r_d_x <= (MW'(r_c_x) + r_half_x) >>> SHIFT;
            r_d_y <= (MW'(r_c_y) + r_half_y) >>> SHIFT;

            // Biased so that every unsaturated result has a 16-bit quotient.
            r_e_m <= r_d_m;
            r_e_x <= r_d_x + r_bias_x;
            r_e_y <= r_d_y + r_bias_y;
        end
    end

    always_comb begin
        init_x.neg = r_e_x[MW-1];
        init_x.ovf = !r_e_x[MW-1]
                   && (r_e_x[MW-1:QUO_W] >= {{(MW-QUO_W-CFG_W){1'b0}}, i_w});
        init_x.rem = r_e_x[QUO_W+CFG_W-1:QUO_W];
        init_x.low = r_e_x[QUO_W-1:0];
        init_x.quo = '0;
        init_y.neg = r_e_y[MW-1];
        init_y.ovf = !r_e_y[MW-1]
                   && (r_e_y[MW-1:QUO_W] >= {{(MW-QUO_W-CFG_W){1'b0}}, i_h});
        init_y.rem = r_e_y[QUO_W+CFG_W-1:QUO_W];
        init_y.low = r_e_y[QUO_W-1:0];
        init_y.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm[0] <= r_e_m;
            r_dx[0] <= init_x;
            r_dy[0] <= init_y;
        end
    end

    for (genvar gj = 0; gj < QUO_W; gj++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gj+1] <= 1'b0;
            end else if (en) begin
                r_dv[gj+1] <= r_dv[gj];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dm[gj+1] <= r_dm[gj];
                r_dx[gj+1] <= div_step(r_dx[gj], i_w);
                r_dy[gj+1] <= div_step(r_dy[gj], i_h);
            end
        end
    end

    always_comb begin
        if (r_dx[QUO_W].neg) begin
            n_o_x = 16'sh8000;
        end else if (r_dx[QUO_W].ovf) begin
            n_o_x = 16'sh7FFF;
        end else begin
            n_o_x = $signed(r_dx[QUO_W].quo ^ 16'h8000);
        end
        if (r_dy[QUO_W].neg) begin
            n_o_y = 16'sh7FFF;
        end else if (r_dy[QUO_W].ovf) begin
            n_o_y = 16'sh8000;
        end else begin
            n_o_y = $signed(16'h7FFF - r_dy[QUO_W].quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_m <= r_dm[QUO_W];
            r_o_x <= n_o_x;
            r_o_y <= n_o_y;
        end
    end

    assign o_valid     = r_o_v;
    assign o_ndc_x     = r_o_x;
    assign o_ndc_y     = r_o_y;
    assign o_color_out = r_o_m.color;
    assign o_corner    = r_o_m.corner;
    assign o_last      = r_o_m.last;

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= VTX_LAST)
        else $error("vertex counter out of range");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_m.last |-> r_o_m.corner == CORNER_BL)
        else $error("last vertex is not the bottom-left corner");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("queue popped while empty");

    a_issue_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && (r_k == VTX_LAST) |=> r_k == 3'd0)
        else $error("vertex counter did not wrap after the sixth vertex");

endmodule
